/* rtl/core/soundex_word_encoder_top_defines.svh */
// assertion macros used by the port checker
`ifndef SOUNDEX_WORD_ENCODER_TOP_DEFINES_SVH
`define SOUNDEX_WORD_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SDX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdx assertion failed");

// next-cycle implication
`define SDX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdx assertion failed");

`endif

/* rtl/core/sdx_pkg.sv */
package sdx_pkg;

    localparam int CHAR_W  = 8;
    localparam int CODE_W  = 3;
    localparam int NUM_KEPT = 3;
    localparam int COUNT_W = 2;
    localparam int M_TDATA_W = 24;

    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'h41;
    localparam logic [CHAR_W-1:0] LETTER_TOP  = 8'h5A;
    localparam logic [CHAR_W-1:0] LOWER_BASE  = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_TOP   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_P        = 8'h50;
    localparam logic [CHAR_W-1:0] CH_H        = 8'h48;
    localparam logic [CHAR_W-1:0] CH_F        = 8'h46;

    localparam logic [CODE_W-1:0]  NO_CODE    = 3'd7;
    localparam logic [CODE_W-1:0]  ZERO_CODE  = 3'd0;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 2'd3;

    // per-character info handed from the classifier to the word logic
    typedef struct packed {
        logic [CHAR_W-1:0] folded;
        logic              is_letter;
        logic              is_space;
        logic [CODE_W-1:0] code;
    } sdx_char_t;

    // soundex digit for letter index 0 (A) .. 25 (Z)
    function automatic logic [CODE_W-1:0] letter_code(input logic [4:0] idx);
        logic [CODE_W-1:0] c;
        case (idx)
            5'd1, 5'd5, 5'd15, 5'd21:                       c = 3'd1;
            5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18,
            5'd23, 5'd25:                                   c = 3'd2;
            5'd3, 5'd19:                                    c = 3'd3;
            5'd11:                                          c = 3'd4;
            5'd12, 5'd13:                                   c = 3'd5;
            5'd17:                                          c = 3'd6;
            default:                                        c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/sdx_char_class.sv */
module sdx_char_class (
    input  logic [sdx_pkg::CHAR_W-1:0] ch,
    output sdx_pkg::sdx_char_t         info
);

    logic                         is_lower;
    logic [sdx_pkg::CHAR_W-1:0]   folded;
    logic [4:0]                   offset;

    always_comb begin
        is_lower = (ch >= sdx_pkg::LOWER_BASE) && (ch <= sdx_pkg::LOWER_TOP);
        folded   = is_lower ? (ch - sdx_pkg::CASE_OFFSET) : ch;
        offset   = 5'(folded - sdx_pkg::LETTER_BASE);

        info.folded    = folded;
        info.is_letter = (folded >= sdx_pkg::LETTER_BASE) && (folded <= sdx_pkg::LETTER_TOP);
        info.is_space  = (folded == sdx_pkg::CH_SPACE);
        info.code      = sdx_pkg::letter_code(offset);
    end

endmodule

/* rtl/core/soundex_word_encoder_top.sv */
// channel | dir | tdata (low bit up)                         | tuser    | tlast
// s_      | in  | ch[7:0]                                     | -        | last_char
// m_      | out | lead_letter[7:0], code_one, code_two,       | bad_word | -
//         |     | code_three (3 bits each), zero pad to 24    |          |
//
// one character per cycle, sustained, whatever the word length, unless a last character waits on a stalled m_
// a word's result shows on m_ once its last character has passed both registers:
// the character sits in the input register until the result register is free,
// and the result register loads at the next edge
// aresetn (sync, active low) empties both registers and starts a new word
// the input register keeps moving while a result waits, unless the character
// in it is a last character that would need the occupied result register
module soundex_word_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic        s_tlast,   // last character of the word
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // lead_letter[7:0], code_one[10:8], code_two[13:11],
                                   // code_three[16:14], zero [23:17]
    output logic        m_tuser    // bad_word
);

    localparam int CW = sdx_pkg::CODE_W;

    // input register
    logic                       in_valid_reg, in_valid_next;
    logic [sdx_pkg::CHAR_W-1:0] in_ch_reg,    in_ch_next;
    logic                       in_last_reg,  in_last_next;

    // word state
    logic                        in_word_reg,  in_word_next;
    logic                        check_h_reg,  check_h_next;
    logic [sdx_pkg::CHAR_W-1:0]  held_reg,     held_next;
    logic [CW-1:0]               prev_reg,     prev_next;
    logic [CW-1:0]               kept_reg  [sdx_pkg::NUM_KEPT];
    logic [CW-1:0]               kept_next [sdx_pkg::NUM_KEPT];
    logic [sdx_pkg::COUNT_W-1:0] count_reg,    count_next;
    logic                        err_reg,      err_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg,  out_data_next;
    logic        out_bad_reg,   out_bad_next;

    logic               step;      // character in the input register is processed
    logic               out_free;  // result register can take a new word
    sdx_pkg::sdx_char_t info;

    sdx_char_class u_class (
        .ch   (in_ch_reg),
        .info (info)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || step;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_ch_next    = in_ch_reg;
        in_last_next  = in_last_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_ch_next    = s_tdata;
            in_last_next  = s_tlast;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    // word state update for one character
    always_comb begin
        in_word_next = in_word_reg;
        check_h_next = check_h_reg;
        held_next    = held_reg;
        prev_next    = prev_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        for (int i = 0; i < sdx_pkg::NUM_KEPT; i++) begin
            kept_next[i] = kept_reg[i];
        end

        if (!in_word_reg) begin
            // first character: start a fresh word
            in_word_next = 1'b1;
            held_next    = info.folded;
            err_next     = !info.is_letter;
            check_h_next = (info.folded == sdx_pkg::CH_P);
            prev_next    = sdx_pkg::NO_CODE;
            count_next   = '0;
            for (int i = 0; i < sdx_pkg::NUM_KEPT; i++) begin
                kept_next[i] = sdx_pkg::ZERO_CODE;
            end
        end else begin
            if (info.is_space) begin
                err_next = 1'b1;
            end
            check_h_next = 1'b0;
            if (check_h_reg && (info.folded == sdx_pkg::CH_H)) begin
                // ph start: lead letter becomes f, the h is not coded
                held_next = sdx_pkg::CH_F;
            end else if (info.is_letter && (info.code != prev_reg)) begin
                prev_next = info.code;
                if ((info.code != sdx_pkg::ZERO_CODE) && (count_reg != sdx_pkg::COUNT_FULL)) begin
                    case (count_reg)
                        2'd0:    kept_next[0] = info.code;
                        2'd1:    kept_next[1] = info.code;
                        2'd2:    kept_next[2] = info.code;
                        default: kept_next[0] = kept_reg[0];
                    endcase
                    count_next = count_reg + 2'd1;
                end
            end
        end

        // end of word: next character starts over
        if (in_last_reg) begin
            in_word_next = 1'b0;
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_bad_next   = out_bad_reg;
        if (step && in_last_reg) begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0, kept_next[2], kept_next[1], kept_next[0], held_next};
            out_bad_next   = err_next;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            in_word_reg   <= 1'b0;
            check_h_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step) begin
                in_word_reg <= in_word_next;
                check_h_reg <= check_h_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_ch_reg    <= in_ch_next;
        in_last_reg  <= in_last_next;
        out_data_reg <= out_data_next;
        out_bad_reg  <= out_bad_next;
        if (step) begin
            held_reg  <= held_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            for (int i = 0; i < sdx_pkg::NUM_KEPT; i++) begin
                kept_reg[i] <= kept_next[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

endmodule

/* rtl/core/sdx_port_checker.sv */
`include "soundex_word_encoder_top_defines.svh"

module sdx_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    logic       out_stall;
    logic [2:0] code_one;
    logic [2:0] code_two;
    logic [2:0] code_three;

    assign out_stall  = m_tvalid && !m_tready;
    assign code_one   = m_tdata[10:8];
    assign code_two   = m_tdata[13:11];
    assign code_three = m_tdata[16:14];

    // a stalled word holds
    `SDX_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable({m_tdata, m_tuser}))

    // padding comes only after the kept codes
    `SDX_ASSERT_NOW(a_pad_order_one, m_tvalid, (code_one != sdx_pkg::ZERO_CODE) || (code_two == sdx_pkg::ZERO_CODE))

    `SDX_ASSERT_NOW(a_pad_order_two, m_tvalid, (code_two != sdx_pkg::ZERO_CODE) || (code_three == sdx_pkg::ZERO_CODE))

    // the three codes are never all NO_CODE at once
    `SDX_ASSERT_NOW(a_code_range, m_tvalid, {code_one, code_two, code_three} != {3{sdx_pkg::NO_CODE}})

    // the fill bits are zero
    `SDX_ASSERT_NOW(a_fill_zero, m_tvalid, m_tdata[23:17] == 7'd0)

endmodule

bind soundex_word_encoder_top sdx_port_checker u_sdx_port_checker (.*);

/* tb/sv/soundex_result_checker.sv */
module soundex_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sdx_pkg::CHAR_W-1:0]    s_tdata,    // ch[7:0]
    input  logic                          s_tlast,    // last character of the word
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sdx_pkg::M_TDATA_W-1:0] m_tdata,    // lead_letter, code_one, code_two,
                                                      // code_three, pad
    input  logic                          m_tuser,    // bad_word
    output int                            error_count,
    output int                            pending_words
);

    typedef struct packed {
        logic [sdx_pkg::CHAR_W-1:0] lead_letter;
        logic [sdx_pkg::CODE_W-1:0] code_one;
        logic [sdx_pkg::CODE_W-1:0] code_two;
        logic [sdx_pkg::CODE_W-1:0] code_three;
        logic                       bad_word;
    } word_code_t;

    // soundex digit per letter, A first
    localparam logic [sdx_pkg::CODE_W-1:0] DIGIT_OF_LETTER [26] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0,
        3'd2, 3'd2, 3'd4, 3'd5, 3'd5, 3'd0, 3'd1, 3'd2, 3'd6,
        3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
    };

    word_code_t        expected_codes [$];
    int                mismatch_total = 0;

    logic                        in_word;
    logic                        check_h;
    logic [sdx_pkg::CHAR_W-1:0]  held_letter;
    logic [sdx_pkg::CODE_W-1:0]  prev_code;
    logic [sdx_pkg::CODE_W-1:0]  kept_codes [sdx_pkg::NUM_KEPT];
    logic [sdx_pkg::COUNT_W-1:0] kept_count;
    logic                        error_seen;

    function automatic logic is_letter(input logic [sdx_pkg::CHAR_W-1:0] c);
        return c >= sdx_pkg::LETTER_BASE && c <= sdx_pkg::LETTER_TOP;
    endfunction

    task automatic clear_word();
        in_word     = 1'b0;
        check_h     = 1'b0;
        held_letter = '0;
        prev_code   = sdx_pkg::NO_CODE;
        kept_count  = '0;
        error_seen  = 1'b0;
        for (int i = 0; i < sdx_pkg::NUM_KEPT; i++) kept_codes[i] = sdx_pkg::ZERO_CODE;
    endtask

    // advance the word state by one character, queue a code on the last one
    task automatic take_char(input logic [sdx_pkg::CHAR_W-1:0] raw, input logic last);
        logic [sdx_pkg::CHAR_W-1:0] c;
        logic [sdx_pkg::CODE_W-1:0] digit;
        word_code_t                 code;
        c = (raw >= sdx_pkg::LOWER_BASE && raw <= sdx_pkg::LOWER_TOP) ?
            raw - sdx_pkg::CASE_OFFSET : raw;
        if (!in_word) begin
            clear_word();
            in_word     = 1'b1;
            held_letter = c;
            error_seen  = !is_letter(c);
            check_h     = (c == sdx_pkg::CH_P);
        end else begin
            if (c == sdx_pkg::CH_SPACE) error_seen = 1'b1;
            if (check_h && c == sdx_pkg::CH_H) begin
                held_letter = sdx_pkg::CH_F;
                check_h     = 1'b0;
            end else begin
                check_h = 1'b0;
                if (is_letter(c)) begin
                    digit = DIGIT_OF_LETTER[c - sdx_pkg::LETTER_BASE];
                    if (digit != prev_code) begin
                        prev_code = digit;
                        if (digit != sdx_pkg::ZERO_CODE && kept_count < sdx_pkg::COUNT_FULL) begin
                            kept_codes[kept_count] = digit;
                            kept_count++;
                        end
                    end
                end
            end
        end
        if (last) begin
            code.lead_letter = held_letter;
            code.code_one    = kept_codes[0];
            code.code_two    = kept_codes[1];
            code.code_three  = kept_codes[2];
            code.bad_word    = error_seen;
            expected_codes.push_back(code);
            clear_word();
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        word_code_t want;
        if (!aresetn) begin
            clear_word();
            expected_codes.delete();
        end else begin
            if (s_tvalid && s_tready) take_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: unexpected code, expected none actual tdata %h tuser %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = expected_codes.pop_front();
                    check_field("lead_letter", want.lead_letter, m_tdata[7:0]);
                    check_field("code_one", want.code_one, m_tdata[10:8]);
                    check_field("code_two", want.code_two, m_tdata[13:11]);
                    check_field("code_three", want.code_three, m_tdata[16:14]);
                    check_field("tdata pad", 0, m_tdata[sdx_pkg::M_TDATA_W-1:17]);
                    check_field("bad_word", want.bad_word, m_tuser);
                end
            end
        end
        error_count   <= mismatch_total;
        pending_words <= expected_codes.size();
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;

    // clock and the one reset at the start
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input channel, quiet until reset is over
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sdx_pkg::CHAR_W-1:0]    s_tdata  = '0;
    logic                          s_tlast  = 1'b0;

    // result channel
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [sdx_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;

    int error_count;
    int pending_words;

    // random gaps on both sides while set, cleared for the last stretch
    bit idle_en = 1'b1;
    // one long hold on the result side, asked by the sender, done by the receiver
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    int                         items_sent = 0;
    logic [sdx_pkg::CHAR_W-1:0] word_chars [$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    soundex_word_encoder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    soundex_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_words (pending_words)
    );

    // send word_chars as one word, tlast on the final character
    task automatic send_word();
        for (int i = 0; i < word_chars.size(); i++) begin
            // sender gap now and then
            if (idle_en && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= word_chars[i];
            s_tlast  <= (i == word_chars.size() - 1);
            do @(posedge aclk); while (!s_tready);
            items_sent++;
        end
    endtask

    task automatic send_text(input string w);
        word_chars.delete();
        for (int i = 0; i < w.len(); i++) word_chars.push_back(w[i]);
        send_word();
    endtask

    // any letter, upper or lower case
    function automatic logic [sdx_pkg::CHAR_W-1:0] pick_letter();
        logic [sdx_pkg::CHAR_W-1:0] l;
        l = sdx_pkg::LETTER_BASE + sdx_pkg::CHAR_W'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) l = l + sdx_pkg::CASE_OFFSET;
        return l;
    endfunction

    // mostly letters, with vowels, h, spaces and arbitrary bytes mixed in
    function automatic logic [sdx_pkg::CHAR_W-1:0] pick_char();
        string vowels;
        logic [sdx_pkg::CHAR_W-1:0] c;
        vowels = "AEIOUYHWaeiouyhw";
        case ($urandom_range(0, 9))
            5:       c = vowels[$urandom_range(0, 15)];
            6:       c = sdx_pkg::CHAR_W'($urandom_range(0, 255));
            7:       c = sdx_pkg::CH_SPACE;
            8:       c = $urandom_range(0, 1) ? sdx_pkg::CH_H
                                              : sdx_pkg::CH_H + sdx_pkg::CASE_OFFSET;
            default: c = pick_letter();
        endcase
        return c;
    endfunction

    // receiver: short random stalls, one long hold, then always ready
    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                // long enough for both internal registers to fill and s_tready to drop
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold_done = 1'b1;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words
        send_text("Z");                           // single character word
        send_text("phl");                         // lower-case ph start, lead becomes F
        word_chars.delete();                      // top byte as a whole word, bad
        word_chars.push_back(8'hFF);
        send_word();
        send_text("a z");                         // space inside the word, bad
        send_text("Tymczak");                     // repeats, vowel split, count saturates
        word_chars.delete();                      // zero byte leads, bad
        word_chars.push_back(8'h00);
        word_chars.push_back(8'h41);
        send_word();
        send_text("bf@p");                        // non-letter keeps the previous digit
        send_text("PHH");                         // upper-case ph, second h gets coded

        // random words, mostly well formed
        while (items_sent < 1000) begin
            if (items_sent > 300) long_hold_req = 1'b1;
            if (items_sent > 850) idle_en = 1'b0;
            word_chars.delete();
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // p start, often followed by h
                    word_chars.push_back($urandom_range(0, 1) ? sdx_pkg::CH_P
                                         : sdx_pkg::CH_P + sdx_pkg::CASE_OFFSET);
                    if ($urandom_range(0, 1))
                        word_chars.push_back($urandom_range(0, 1) ? sdx_pkg::CH_H
                                             : sdx_pkg::CH_H + sdx_pkg::CASE_OFFSET);
                end
                2:       word_chars.push_back(sdx_pkg::CHAR_W'($urandom_range(0, 255)));
                default: word_chars.push_back(pick_letter());
            endcase
            while (word_chars.size() < len) word_chars.push_back(pick_char());
            send_word();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);

        // drain, then idle for anything stray
        while (pending_words != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 200000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
